### design/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// aesctr_pkg
// Shared types, constants and byte-level helpers of the AES-128 CTR core.
// ----------------------------------------------------------------------------
package aesctr_pkg;

   localparam int unsigned STATE_BYTES = 16;
   localparam int unsigned ROUNDS      = 10;
   localparam logic [4:0]  BLOCK_BYTES = 5'd16;
   localparam int unsigned CSR_AW      = 5;

   // Register index, taken from paddr[4:3].
   localparam logic [1:0] REG_KEY_HIGH = 2'd0;
   localparam logic [1:0] REG_KEY_LOW  = 2'd1;
   localparam logic [1:0] REG_NONCE    = 2'd2;

   typedef struct packed {
      logic [127:0] key;
      logic [63:0]  nonce;
   } cfg_type;

   // Side data that travels with each block through the rounds.
   typedef struct packed {
      logic [127:0] data;
      logic [4:0]   cnt;
      logic         wrap;
   } aux_type;

   typedef logic [7:0] state_arr_type [STATE_BYTES];

   localparam logic [7:0] RCON [ROUNDS] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xt(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte 0 of a block sits in the top bits of the 128-bit word.
   function automatic state_arr_type unpack_state(input logic [127:0] s);
      state_arr_type a;
      for (int q = 0; q < STATE_BYTES; q++) begin
         a[q] = s[127 - 8*q -: 8];
      end
      return a;
   endfunction

   function automatic logic [127:0] pack_state(input state_arr_type a);
      logic [127:0] s;
      for (int q = 0; q < STATE_BYTES; q++) begin
         s[127 - 8*q -: 8] = a[q];
      end
      return s;
   endfunction

endpackage

### design/aesctr_csr.sv
// ----------------------------------------------------------------------------
// aesctr_csr
// Key and nonce registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module aesctr_csr import aesctr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output cfg_type           cfg
);

   logic [63:0] key_high_ff;
   logic [63:0] key_low_ff;
   logic [63:0] nonce_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         nonce_ff    <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_KEY_HIGH: key_high_ff <= pwdata;
            REG_KEY_LOW:  key_low_ff  <= pwdata;
            REG_NONCE:    nonce_ff    <= pwdata;
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KEY_HIGH: prdata = key_high_ff;
         REG_KEY_LOW:  prdata = key_low_ff;
         REG_NONCE:    prdata = nonce_ff;
         default:      prdata = '0;
      endcase
   end

   assign cfg.key   = {key_high_ff, key_low_ff};
   assign cfg.nonce = nonce_ff;

endmodule

### design/aesctr_round.sv
// ----------------------------------------------------------------------------
// aesctr_round
// One AES-128 encryption round together with the matching key expansion step.
// ----------------------------------------------------------------------------
module aesctr_round import aesctr_pkg::*; (
   input  logic [127:0] st_i,
   input  logic [127:0] rk_i,
   input  logic [7:0]   rcon,
   input  logic         final_round,
   output logic [127:0] st_o,
   output logic [127:0] rk_o
);

   state_arr_type s_in;
   state_arr_type k_in;
   state_arr_type k_nx;
   state_arr_type sb;
   state_arr_type sr;
   state_arr_type mc;
   state_arr_type res;
   logic [7:0]    t [4];

   always_comb begin
      s_in = unpack_state(st_i);
      k_in = unpack_state(rk_i);

      // Next round key: rotate and substitute the last word, then chain.
      t[0] = SBOX[k_in[13]] ^ rcon;
      t[1] = SBOX[k_in[14]];
      t[2] = SBOX[k_in[15]];
      t[3] = SBOX[k_in[12]];
      for (int j = 0; j < 4; j++) begin
         k_nx[j] = k_in[j] ^ t[j];
      end
      for (int w = 1; w < 4; w++) begin
         for (int j = 0; j < 4; j++) begin
            k_nx[4*w + j] = k_in[4*w + j] ^ k_nx[4*(w-1) + j];
         end
      end

      for (int q = 0; q < STATE_BYTES; q++) begin
         sb[q] = SBOX[s_in[q]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sr[r + 4*c] = sb[r + 4*((c + r) & 3)];
         end
      end
      for (int c = 0; c < 4; c++) begin
         mc[4*c]     = xt(sr[4*c]) ^ xt(sr[4*c+1]) ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
         mc[4*c + 1] = sr[4*c] ^ xt(sr[4*c+1]) ^ xt(sr[4*c+2]) ^ sr[4*c+2] ^ sr[4*c+3];
         mc[4*c + 2] = sr[4*c] ^ sr[4*c+1] ^ xt(sr[4*c+2]) ^ xt(sr[4*c+3]) ^ sr[4*c+3];
         mc[4*c + 3] = xt(sr[4*c]) ^ sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ xt(sr[4*c+3]);
      end

      // The last round has no column mix.
      for (int q = 0; q < STATE_BYTES; q++) begin
         res[q] = (final_round ? sr[q] : mc[q]) ^ k_nx[q];
      end

      st_o = pack_state(res);
      rk_o = pack_state(k_nx);
   end

endmodule

### design/aes128_ctr_block_cipher_core.sv
// ----------------------------------------------------------------------------
// aes128_ctr_block_cipher_core
// AES-128 counter-mode cipher, one 16-byte block per beat, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Program key_high, key_low and nonce over the CSR port while the core is
//   idle. Each req beat carries a 16-byte block and its valid byte count; a
//   req_type of 1 restarts the block counter at zero for that beat. Each rsp
//   beat returns the block XORed with AES-128(key, nonce || counter), with the
//   counter bytes in little-endian order, bytes past the count zeroed, and
//   counter_wrapped set on the beat whose counter advance passed the maximum.
// From acceptance to rsp_valid a beat passes an input stage that does the
// counter update and first key addition, then nine round stages and a result
// register that also holds the last round. One beat is accepted every cycle
// while req_stall is low. A stall on rsp holds the result register; the stage
// registers still fill bubbles, and req_stall rises once every stage and
// the result register are occupied.
// Reset clears the key, the nonce, the block counter and all valid bits.
// ----------------------------------------------------------------------------
module aes128_ctr_block_cipher_core import aesctr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [63:0]       req_block_high,
   input  logic [63:0]       req_block_low,
   input  logic [4:0]        req_valid_bytes,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [63:0]       rsp_out_high,
   output logic [63:0]       rsp_out_low,
   output logic [4:0]        rsp_out_bytes,
   output logic              rsp_counter_wrapped,
   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

   cfg_type       cfg;
   logic [63:0]   counter_ff;
   logic [63:0]   counter_in;
   logic [63:0]   ctr_use;
   logic          req_acc;
   logic [127:0]  st0_in;
   aux_type       aux0_in;

   logic          vld_ff [ROUNDS];
   logic [127:0]  st_ff  [ROUNDS];
   logic [127:0]  rk_ff  [ROUNDS];
   aux_type       aux_ff [ROUNDS];
   logic          can    [ROUNDS];
   logic          can_out;

   logic [127:0]  rnd_st [ROUNDS];
   logic [127:0]  rnd_rk [ROUNDS];

   logic          rsp_valid_ff;
   logic [127:0]  rsp_data_ff;
   logic [127:0]  rsp_data_in;
   logic [4:0]    rsp_bytes_ff;
   logic          rsp_wrap_ff;

   aesctr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   assign pready = 1'b1;

   // Each stage may load when it is empty or its successor can load.
   always_comb begin
      can_out         = !rsp_valid_ff || !rsp_stall;
      can[ROUNDS-1]   = !vld_ff[ROUNDS-1] || can_out;
      for (int i = ROUNDS - 2; i >= 0; i--) begin
         can[i] = !vld_ff[i] || can[i+1];
      end
   end

   assign req_stall = !can[0];
   assign req_acc   = req_valid && can[0];

   // Counter block and first key addition.
   always_comb begin
      ctr_use = req_type ? '0 : counter_ff;
      if (ctr_use == '1) begin
         counter_in   = 64'd1;
         aux0_in.wrap = 1'b1;
      end else begin
         counter_in   = ctr_use + 64'd1;
         aux0_in.wrap = 1'b0;
      end
      st0_in[127:64] = cfg.nonce;
      for (int q = 0; q < 8; q++) begin
         st0_in[63 - 8*q -: 8] = ctr_use[8*q +: 8];
      end
      st0_in       = st0_in ^ cfg.key;
      aux0_in.data = {req_block_high, req_block_low};
      aux0_in.cnt  = (req_valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : req_valid_bytes;
   end

   for (genvar k = 0; k < ROUNDS; k++) begin : g_round
      aesctr_round u_round (
         .st_i        (st_ff[k]),
         .rk_i        (rk_ff[k]),
         .rcon        (RCON[k]),
         .final_round (k == ROUNDS - 1),
         .st_o        (rnd_st[k]),
         .rk_o        (rnd_rk[k])
      );
   end

   // Keystream XOR and masking of bytes past the count.
   always_comb begin
      for (int q = 0; q < STATE_BYTES; q++) begin
         if (5'(q) < aux_ff[ROUNDS-1].cnt) begin
            rsp_data_in[127 - 8*q -: 8] = aux_ff[ROUNDS-1].data[127 - 8*q -: 8]
                                        ^ rnd_st[ROUNDS-1][127 - 8*q -: 8];
         end else begin
            rsp_data_in[127 - 8*q -: 8] = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ROUNDS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         if (req_acc) begin
            counter_ff <= counter_in;
         end
         if (can[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < ROUNDS; i++) begin
            if (can[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
         if (can_out) begin
            rsp_valid_ff <= vld_ff[ROUNDS-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (can[0]) begin
         st_ff[0]  <= st0_in;
         rk_ff[0]  <= cfg.key;
         aux_ff[0] <= aux0_in;
      end
      for (int i = 1; i < ROUNDS; i++) begin
         if (can[i]) begin
            st_ff[i]  <= rnd_st[i-1];
            rk_ff[i]  <= rnd_rk[i-1];
            aux_ff[i] <= aux_ff[i-1];
         end
      end
      if (can_out) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_bytes_ff <= aux_ff[ROUNDS-1].cnt;
         rsp_wrap_ff  <= aux_ff[ROUNDS-1].wrap;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_high        = rsp_data_ff[127:64];
   assign rsp_out_low         = rsp_data_ff[63:0];
   assign rsp_out_bytes       = rsp_bytes_ff;
   assign rsp_counter_wrapped = rsp_wrap_ff;

`ifndef SYNTHESIS
   a_wrap_to_one: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !req_type && counter_ff == '1) |=> (counter_ff == 64'd1))
      else $error("block counter did not wrap to one");

   a_bytes_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_bytes <= BLOCK_BYTES))
      else $error("byte count above block size");

   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_bytes == 5'd0) |-> (rsp_out_high == '0 && rsp_out_low == '0))
      else $error("result bytes not cleared for empty block");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && vld_ff[0]))
      else $error("request stalled with room in the pipeline");
`endif

endmodule
